// ===== src/utf8r_pkg.sv =====
package utf8r_pkg;

    // field widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned SH_W   = 16;
    localparam int unsigned CP_W   = 21;

    // replacement character for stray and truncated sequences
    localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

    // code points decoded from one transaction, in text order
    typedef struct packed {
        logic [2:0]                 ncp;
        logic [3:0][CP_W-1:0]       cp;
        logic [3:0][SH_W-1:0]       sh;
    } t_grp;

    // roll class of a code point
    typedef enum logic [1:0] {
        KIND_OTHER,
        KIND_UPPER,
        KIND_LOWER,
        KIND_DIGIT
    } t_kind;

    // sequence length from the lead byte, zero for a stray byte
    function automatic logic [2:0] lead_len(input logic [BYTE_W-1:0] c);
        logic [2:0] n;
        priority if (c[7] == 1'b0) begin
            n = 3'd1;
        end else if (c[7:5] == 3'b110) begin
            n = 3'd2;
        end else if (c[7:4] == 4'hE) begin
            n = 3'd3;
        end else if (c[7:3] == 5'h1E) begin
            n = 3'd4;
        end else begin
            n = 3'd0;
        end
        return n;
    endfunction

endpackage

// ===== src/utf8r_front.sv =====
module utf8r_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [23:0]        s_axis_tdata,   // [7:0] in_byte, [23:8] shift
    input  logic               s_axis_tlast,   // text_end
    input  logic               i_q_ready,
    output logic               o_push,
    output utf8r_pkg::t_grp    o_grp
);

    logic [2:0][7:0]  r_pb;
    logic [2:0][15:0] r_ps;
    logic [1:0]       r_cnt;

    logic [2:0][7:0]  n_pb;
    logic [2:0][15:0] n_ps;
    logic [1:0]       n_cnt;

    logic acc;

    assign s_axis_tready = i_q_ready;
    assign acc           = s_axis_tvalid & s_axis_tready;

    // join held bytes with the new one and walk the buffer
    always_comb begin
        logic [3:0][7:0]  wb;
        logic [3:0][15:0] ws;
        logic [2:0]       len;
        logic [2:0]       pos;
        logic [2:0]       need;
        logic [2:0]       adv;
        logic [2:0]       ncp;
        logic             stop;
        logic             emit;
        logic [20:0]      cp;
        logic [7:0]       c;
        logic [7:0]       b1;
        logic [7:0]       b2;
        logic [7:0]       b3;

        for (int j = 0; j < 3; j++) begin
            wb[j] = (2'(j) < r_cnt) ? r_pb[j] : s_axis_tdata[7:0];
            ws[j] = (2'(j) < r_cnt) ? r_ps[j] : s_axis_tdata[23:8];
        end
        wb[3] = s_axis_tdata[7:0];
        ws[3] = s_axis_tdata[23:8];

        len   = {1'b0, r_cnt} + 3'd1;
        pos   = 3'd0;
        ncp   = 3'd0;
        stop  = 1'b0;
        need  = 3'd0;
        adv   = 3'd1;
        emit  = 1'b0;
        cp    = utf8r_pkg::REPL_CP;
        c     = 8'd0;
        b1    = 8'd0;
        b2    = 8'd0;
        b3    = 8'd0;
        n_pb  = r_pb;
        n_ps  = r_ps;
        n_cnt = 2'd0;
        o_grp = '0;

        for (int s = 0; s < 4; s++) begin
            if (!stop && (pos < len)) begin
                c    = wb[pos[1:0]];
                b1   = wb[pos[1:0] + 2'd1];
                b2   = wb[pos[1:0] + 2'd2];
                b3   = wb[pos[1:0] + 2'd3];
                need = utf8r_pkg::lead_len(c);
                adv  = 3'd1;
                emit = 1'b1;
                cp   = utf8r_pkg::REPL_CP;
                if (need == 3'd0) begin
                    cp = utf8r_pkg::REPL_CP;
                end else if (need == 3'd1) begin
                    cp = {13'd0, c};
                end else if ((pos + need) <= len) begin
                    adv = need;
                    if (need == 3'd2) begin
                        cp = {10'd0, c[4:0], b1[5:0]};
                    end else if (need == 3'd3) begin
                        cp = {5'd0, c[3:0], b1[5:0], b2[5:0]};
                    end else begin
                        cp = {c[2:0], b1[5:0], b2[5:0], b3[5:0]};
                    end
                end else if (s_axis_tlast) begin
                    cp = utf8r_pkg::REPL_CP;
                end else begin
                    // unfinished sequence: hold the rest for later
                    emit  = 1'b0;
                    stop  = 1'b1;
                    n_cnt = 2'(len - pos);
                    for (int j = 0; j < 3; j++) begin
                        n_pb[j] = wb[pos[1:0] + 2'(j)];
                        n_ps[j] = ws[pos[1:0] + 2'(j)];
                    end
                end
                if (emit) begin
                    o_grp.cp[ncp[1:0]] = cp;
                    o_grp.sh[ncp[1:0]] = ws[pos[1:0]];
                    ncp = ncp + 3'd1;
                    pos = pos + adv;
                end
            end
        end
        o_grp.ncp = ncp;
    end

    assign o_push = acc && (o_grp.ncp != 3'd0);

    // held sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (acc) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_pb <= n_pb;
            r_ps <= n_ps;
        end
    end

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && s_axis_tlast) |=> (r_cnt == 2'd0))
        else $error("held bytes survive end of text");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_grp.ncp <= 3'd4))
        else $error("more than four code points from one transaction");

endmodule

// ===== src/utf8r_fifo.sv =====
module utf8r_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  utf8r_pkg::t_grp    i_wdata,
    output logic               o_ready,
    output logic               o_valid,
    output utf8r_pkg::t_grp    o_rdata,
    input  logic               i_pop
);

    utf8r_pkg::t_grp r_mem [2];
    logic            r_wr;
    logic            r_rd;
    logic [1:0]      r_cnt;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_rdata = r_mem[r_rd];

    // two-entry queue between decoder and encoder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != 2'd2))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != 2'd0))
        else $error("pop from empty queue");

endmodule

// ===== src/utf8r_back.sv =====
module utf8r_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  utf8r_pkg::t_grp    i_q_data,
    output logic               o_q_pop,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata,   // [7:0] out_byte
    output logic               m_axis_tlast    // run_last
);

    // reciprocals for exact quotients of values below 2^18
    localparam logic [17:0] MUL26 = 18'd161320;
    localparam logic [17:0] MUL10 = 18'd104858;
    // bias multiples of the modulus that lift the sum above zero
    localparam logic [16:0] BIAS26 = 17'd32786;
    localparam logic [16:0] BIAS10 = 17'd32770;

    function automatic logic [20:0] kind_base(input utf8r_pkg::t_kind k);
        logic [20:0] b;
        unique case (k)
            utf8r_pkg::KIND_UPPER: b = 21'h41;
            utf8r_pkg::KIND_LOWER: b = 21'h61;
            utf8r_pkg::KIND_DIGIT: b = 21'h30;
            default:               b = 21'h0;
        endcase
        return b;
    endfunction

    // head selection
    logic [1:0]  r_idx;
    logic [20:0] h_cp;
    logic [15:0] h_sh;
    logic        h_last;

    // stage 1
    logic                r_v1;
    logic [20:0]         r_cp;
    utf8r_pkg::t_kind    r_kind;
    logic [16:0]         r_x;
    logic [12:0]         r_q;
    logic                r_last1;

    // serialiser
    logic                r_sv;
    logic [3:0][7:0]     r_sb;
    logic [1:0]          r_scnt;
    logic [1:0]          r_sidx;
    logic                r_slast;

    utf8r_pkg::t_kind    h_kind;
    logic [16:0]         h_x;
    logic [34:0]         h_prod;
    logic [12:0]         h_q;
    logic [4:0]          h_off;

    logic [16:0]         rem;
    logic [20:0]         rolled;
    logic [3:0][7:0]     enc_b;
    logic [1:0]          enc_cnt;

    logic out_fire;
    logic last_byte;
    logic ser_free;
    logic ser_load;
    logic s1_take;

    assign h_cp   = i_q_data.cp[r_idx];
    assign h_sh   = i_q_data.sh[r_idx];
    assign h_last = ({1'b0, r_idx} == (i_q_data.ncp - 3'd1));

    // classify and form the biased offset
    always_comb begin
        priority if (h_sh == 16'd0) begin
            h_kind = utf8r_pkg::KIND_OTHER;
        end else if (h_cp >= 21'h41 && h_cp <= 21'h5A) begin
            h_kind = utf8r_pkg::KIND_UPPER;
        end else if (h_cp >= 21'h61 && h_cp <= 21'h7A) begin
            h_kind = utf8r_pkg::KIND_LOWER;
        end else if (h_cp >= 21'h30 && h_cp <= 21'h39) begin
            h_kind = utf8r_pkg::KIND_DIGIT;
        end else begin
            h_kind = utf8r_pkg::KIND_OTHER;
        end
    end

    assign h_off  = 5'(h_cp - kind_base(h_kind));
    assign h_x    = {h_sh[15], h_sh} + {12'd0, h_off}
                  + ((h_kind == utf8r_pkg::KIND_DIGIT) ? BIAS10 : BIAS26);
    assign h_prod = 35'(h_x) * 35'((h_kind == utf8r_pkg::KIND_DIGIT) ? MUL10 : MUL26);
    assign h_q    = (h_kind == utf8r_pkg::KIND_DIGIT) ? h_prod[32:20] : h_prod[34:22];

    // remainder and rolled code point
    assign rem = r_x - (17'(r_q) * ((r_kind == utf8r_pkg::KIND_DIGIT) ? 17'd10 : 17'd26));
    assign rolled = (r_kind == utf8r_pkg::KIND_OTHER) ? r_cp
                  : kind_base(r_kind) + {16'd0, rem[4:0]};

    // shortest UTF-8 form
    always_comb begin
        enc_b = '0;
        priority if (rolled < 21'h80) begin
            enc_b[0] = rolled[7:0];
            enc_cnt  = 2'd0;
        end else if (rolled < 21'h800) begin
            enc_b[0] = 8'hC0 | {3'd0, rolled[10:6]};
            enc_b[1] = 8'h80 | {2'd0, rolled[5:0]};
            enc_cnt  = 2'd1;
        end else if (rolled < 21'h10000) begin
            enc_b[0] = 8'hE0 | {4'd0, rolled[15:12]};
            enc_b[1] = 8'h80 | {2'd0, rolled[11:6]};
            enc_b[2] = 8'h80 | {2'd0, rolled[5:0]};
            enc_cnt  = 2'd2;
        end else begin
            enc_b[0] = 8'hF0 | {5'd0, rolled[20:18]};
            enc_b[1] = 8'h80 | {2'd0, rolled[17:12]};
            enc_b[2] = 8'h80 | {2'd0, rolled[11:6]};
            enc_b[3] = 8'h80 | {2'd0, rolled[5:0]};
            enc_cnt  = 2'd3;
        end
    end

    // flow control
    assign out_fire  = r_sv && m_axis_tready;
    assign last_byte = (r_sidx == r_scnt);
    assign ser_free  = !r_sv || (out_fire && last_byte);
    assign ser_load  = r_v1 && ser_free;
    assign s1_take   = i_q_valid && (!r_v1 || ser_load);
    assign o_q_pop   = s1_take && h_last;

    assign m_axis_tvalid = r_sv;
    assign m_axis_tdata  = r_sb[r_sidx];
    assign m_axis_tlast  = r_slast && last_byte;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= 2'd0;
            r_v1   <= 1'b0;
            r_sv   <= 1'b0;
            r_sidx <= 2'd0;
        end else begin
            if (s1_take) begin
                r_idx <= h_last ? 2'd0 : r_idx + 2'd1;
                r_v1  <= 1'b1;
            end else if (ser_load) begin
                r_v1  <= 1'b0;
            end
            if (ser_load) begin
                r_sv   <= 1'b1;
                r_sidx <= 2'd0;
            end else if (out_fire) begin
                if (last_byte) begin
                    r_sv <= 1'b0;
                end else begin
                    r_sidx <= r_sidx + 2'd1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s1_take) begin
            r_cp    <= h_cp;
            r_kind  <= h_kind;
            r_x     <= h_x;
            r_q     <= h_q;
            r_last1 <= h_last;
        end
        if (ser_load) begin
            r_sb    <= enc_b;
            r_scnt  <= enc_cnt;
            r_slast <= r_last1;
        end
    end

    a_sidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> (r_sidx <= r_scnt))
        else $error("serialiser index past burst length");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !ser_load) |=> (r_v1 && $stable(r_cp) && $stable(r_x)))
        else $error("stage one lost its code point under stall");

endmodule

// ===== src/utf8_codepoint_roll_transcoder_core.sv =====
// The first result byte passes the queue, stage one and the serialiser registers.
// Throughput: one input per cycle while each causes at most one byte and the receiver
// is ready; overall one result byte per cycle, paced by the output serialiser.
// A lead byte awaiting continuation bytes produces nothing until completed or the text ends.
// Reset is synchronous, active low; it empties the held bytes and the queue.
module utf8_codepoint_roll_transcoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] in_byte, [23:8] shift
    input  logic        s_axis_tlast,   // text_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast    // run_last
);

    logic            push;
    logic            q_ready;
    logic            q_valid;
    logic            q_pop;
    utf8r_pkg::t_grp w_grp;
    utf8r_pkg::t_grp q_grp;

    utf8r_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_q_ready     (q_ready),
        .o_push        (push),
        .o_grp         (w_grp)
    );

    utf8r_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (w_grp),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_rdata (q_grp),
        .i_pop   (q_pop)
    );

    utf8r_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_data      (q_grp),
        .o_q_pop       (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned BYTE_W = utf8r_pkg::BYTE_W;
    localparam int unsigned SH_W   = utf8r_pkg::SH_W;
    localparam int unsigned CP_W   = utf8r_pkg::CP_W;

    // one byte of re-encoded text with its end-of-run flag
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_out_byte;

    localparam int unsigned UPPER_A = 'h41;
    localparam int unsigned UPPER_Z = 'h5A;
    localparam int unsigned LOWER_A = 'h61;
    localparam int unsigned LOWER_Z = 'h7A;
    localparam int unsigned DIGIT_0 = 'h30;
    localparam int unsigned DIGIT_9 = 'h39;
    localparam int unsigned N_ALPHA = 26;
    localparam int unsigned N_DIGIT = 10;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned PRESSURE_CYCLES = 300;
    localparam int unsigned TAIL_CYCLES = 16;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [SH_W+BYTE_W-1:0]  s_axis_tdata = '0;   // [7:0] in_byte, [23:8] shift
    logic                    s_axis_tlast = 1'b0; // text_end
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [BYTE_W-1:0]       m_axis_tdata;        // [7:0] out_byte
    logic                    m_axis_tlast;        // run_last

    // predictor state: bytes of an unfinished sequence and their shifts
    logic [BYTE_W-1:0]       held_byte [3];
    logic [SH_W-1:0]         held_shift [3];
    int                      held_cnt = 0;

    t_out_byte               exp_bytes [$];
    int                      n_errors = 0;
    int                      items_sent = 0;
    bit                      no_gaps = 1'b0;
    bit                      hold_on = 1'b0;
    int                      stall_left = 0;
    event                    hold_go;

    utf8_codepoint_roll_transcoder_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [SH_W-1:0] rand_shift();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            return '0;
        end else if (r < 65) begin
            return 16'($urandom_range(0, 120) - 60);
        end
        return 16'($urandom);
    endfunction

    function automatic void note_error(string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endfunction

    // decode, roll and re-encode the bytes made complete by one transaction
    function automatic void predict_bytes(logic [BYTE_W-1:0] b, logic [SH_W-1:0] sh,
                                          logic fin);
        logic [BYTE_W-1:0] seq_b [4];
        logic [SH_W-1:0]   seq_s [4];
        int                len;
        int                pos;
        int                need;
        int                adv;
        int                j;
        int                d;
        int                lo;
        int                n;
        int                r;
        logic [CP_W-1:0]   cp;
        logic [BYTE_W-1:0] c;
        utf8r_pkg::t_kind  kind;
        t_out_byte         run_b [12];
        int                n_run;
        bit                held;

        len = 0;
        for (j = 0; j < held_cnt; j++) begin
            seq_b[len] = held_byte[j];
            seq_s[len] = held_shift[j];
            len++;
        end
        seq_b[len] = b;
        seq_s[len] = sh;
        len++;
        held_cnt = 0;
        pos = 0;
        n_run = 0;
        held = 1'b0;

        while (pos < len && !held) begin
            c = seq_b[pos];
            adv = 1;
            if (c[7] == 1'b0) begin
                need = 1;
            end else if (c[7:5] == 3'b110) begin
                need = 2;
            end else if (c[7:4] == 4'hE) begin
                need = 3;
            end else if (c[7:3] == 5'h1E) begin
                need = 4;
            end else begin
                need = 0;
            end

            if (need == 0) begin
                cp = utf8r_pkg::REPL_CP;
            end else if (need == 1) begin
                cp = {13'b0, c};
            end else if (pos + need <= len) begin
                case (need)
                    2: cp = {10'b0, c[4:0], seq_b[pos+1][5:0]};
                    3: cp = {5'b0, c[3:0], seq_b[pos+1][5:0], seq_b[pos+2][5:0]};
                    default: cp = {c[2:0], seq_b[pos+1][5:0], seq_b[pos+2][5:0],
                                   seq_b[pos+3][5:0]};
                endcase
                adv = need;
            end else if (fin) begin
                cp = utf8r_pkg::REPL_CP;
            end else begin
                // sequence still open: keep its bytes for the next transaction
                for (j = 0; pos + j < len && j < 3; j++) begin
                    held_byte[j] = seq_b[pos+j];
                    held_shift[j] = seq_s[pos+j];
                end
                held_cnt = j;
                held = 1'b1;
            end

            if (!held) begin
                // roll letters and digits by the shift of the first byte
                d = int'($signed(seq_s[pos]));
                kind = utf8r_pkg::KIND_OTHER;
                if (cp >= UPPER_A && cp <= UPPER_Z) begin
                    kind = utf8r_pkg::KIND_UPPER;
                end else if (cp >= LOWER_A && cp <= LOWER_Z) begin
                    kind = utf8r_pkg::KIND_LOWER;
                end else if (cp >= DIGIT_0 && cp <= DIGIT_9) begin
                    kind = utf8r_pkg::KIND_DIGIT;
                end
                if (d != 0 && kind != utf8r_pkg::KIND_OTHER) begin
                    case (kind)
                        utf8r_pkg::KIND_UPPER: begin lo = UPPER_A; n = N_ALPHA; end
                        utf8r_pkg::KIND_LOWER: begin lo = LOWER_A; n = N_ALPHA; end
                        default:               begin lo = DIGIT_0; n = N_DIGIT; end
                    endcase
                    r = (int'(cp) - lo + d) % n;
                    if (r < 0) begin
                        r += n;
                    end
                    cp = CP_W'(lo + r);
                end

                // shortest form
                if (cp < 'h80) begin
                    run_b[n_run] = '{cp[7:0], 1'b0};
                    n_run++;
                end else if (cp < 'h800) begin
                    run_b[n_run] = '{{3'b110, cp[10:6]}, 1'b0};
                    run_b[n_run+1] = '{{2'b10, cp[5:0]}, 1'b0};
                    n_run += 2;
                end else if (cp < 'h10000) begin
                    run_b[n_run] = '{{4'hE, cp[15:12]}, 1'b0};
                    run_b[n_run+1] = '{{2'b10, cp[11:6]}, 1'b0};
                    run_b[n_run+2] = '{{2'b10, cp[5:0]}, 1'b0};
                    n_run += 3;
                end else begin
                    run_b[n_run] = '{{5'h1E, cp[20:18]}, 1'b0};
                    run_b[n_run+1] = '{{2'b10, cp[17:12]}, 1'b0};
                    run_b[n_run+2] = '{{2'b10, cp[11:6]}, 1'b0};
                    run_b[n_run+3] = '{{2'b10, cp[5:0]}, 1'b0};
                    n_run += 4;
                end
                pos += adv;
            end
        end

        if (n_run > 0) begin
            run_b[n_run-1].last = 1'b1;
        end
        for (j = 0; j < n_run; j++) begin
            exp_bytes.insert(exp_bytes.size(), run_b[j]);
        end
    endfunction

    // offer one byte after a random gap; predict once the transaction is taken
    task automatic send_byte(logic [BYTE_W-1:0] b, logic [SH_W-1:0] sh, logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {sh, b};
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_bytes(b, sh, fin);
        items_sent++;
    endtask

    // n_bytes of a sequence of the given length; fewer bytes leave it truncated
    task automatic send_seq(int seq_len, int n_bytes, logic fin);
        logic [BYTE_W-1:0] lead;
        int                i;
        int                r;
        case (seq_len)
            1: begin
                r = $urandom_range(0, 5);
                case (r)
                    0: lead = 8'(UPPER_A + $urandom_range(0, N_ALPHA - 1));
                    1: lead = 8'(LOWER_A + $urandom_range(0, N_ALPHA - 1));
                    2: lead = 8'(DIGIT_0 + $urandom_range(0, N_DIGIT - 1));
                    default: lead = {1'b0, 7'($urandom)};
                endcase
            end
            2: lead = {3'b110, 5'($urandom)};
            3: lead = {4'hE, 4'($urandom)};
            default: lead = {5'h1E, 3'($urandom)};
        endcase
        send_byte(lead, rand_shift(), fin && n_bytes == 1);
        for (i = 1; i < n_bytes; i++) begin
            send_byte({2'b10, 6'($urandom)}, 16'($urandom), fin && i == n_bytes - 1);
        end
    endtask

    task automatic test_ascii_roll();
        send_byte(8'h41, 16'h0000, 1'b0);
        send_byte(8'h5A, 16'h0001, 1'b0);
        send_byte(8'h61, 16'hFFFF, 1'b0);
        send_byte(8'h7A, 16'h7FFF, 1'b0);
        send_byte(8'h30, 16'h8000, 1'b0);
        send_byte(8'h00, 16'h0005, 1'b0);
        send_byte(8'h7F, 16'hFFF9, 1'b1);
    endtask

    task automatic test_multibyte();
        // three-byte euro sign, then the largest four-byte value
        send_byte(8'hE2, 16'h0003, 1'b0);
        send_byte(8'h82, 16'h0000, 1'b0);
        send_byte(8'hAC, 16'h0000, 1'b0);
        send_byte(8'hF7, 16'h1234, 1'b0);
        send_byte(8'hBF, 16'hFFFF, 1'b0);
        send_byte(8'hBF, 16'h8000, 1'b0);
        send_byte(8'hBF, 16'h7FFF, 1'b0);
        // overlong 'A' comes out as one rolled byte
        send_byte(8'hC1, 16'h0002, 1'b0);
        send_byte(8'h81, 16'h0000, 1'b1);
    endtask

    task automatic test_stray();
        send_byte(8'h80, 16'h0001, 1'b0);
        send_byte(8'hF8, 16'h0000, 1'b0);
        send_byte(8'hFF, 16'hFFFF, 1'b0);
    endtask

    task automatic test_text_end();
        // truncated lead, then a letter rolled by its own shift
        send_byte(8'hE2, 16'h0007, 1'b0);
        send_byte(8'h41, 16'h0003, 1'b1);
        // truncated four-byte lead: every held byte becomes a replacement
        send_byte(8'hF0, 16'h0000, 1'b0);
        send_byte(8'h80, 16'h0000, 1'b0);
        send_byte(8'h80, 16'h0000, 1'b1);
    endtask

    task automatic test_random(int n_items);
        int start;
        int r;
        int len;
        logic fin;
        start = items_sent;
        while (items_sent - start < n_items) begin
            r = $urandom_range(0, 99);
            fin = ($urandom_range(0, 7) == 0);
            if (r < 70) begin
                len = $urandom_range(1, 4);
                send_seq(len, len, fin);
            end else if (r < 85) begin
                len = $urandom_range(2, 4);
                send_seq(len, $urandom_range(1, len - 1), $urandom_range(0, 1) == 1);
            end else begin
                send_byte(8'($urandom), rand_shift(), fin);
            end
        end
    endtask

    // receiver holds off while the sender streams long sequences
    task automatic test_backpressure();
        int i;
        no_gaps = 1'b1;
        -> hold_go;
        for (i = 0; i < 15; i++) begin
            send_seq($urandom_range(3, 4), 4, 1'b0);
        end
        no_gaps = 1'b0;
    endtask

    // long hold-off, counted in cycles
    initial begin
        forever begin
            @(hold_go);
            hold_on <= 1'b1;
            repeat (PRESSURE_CYCLES) @(posedge i_clk);
            hold_on <= 1'b0;
        end
    end

    // receiver readiness: random stalls plus the long hold-off
    always @(posedge i_clk) begin
        if (hold_on) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
            stall_left <= pick_gap();
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // compare each output transaction with the oldest expected byte
    always @(posedge i_clk) begin
        t_out_byte want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (exp_bytes.size() == 0) begin
                note_error($sformatf("unexpected byte %02h last %0b",
                                     m_axis_tdata, m_axis_tlast));
            end else begin
                want = exp_bytes.pop_front();
                if (m_axis_tdata !== want.data || m_axis_tlast !== want.last) begin
                    note_error($sformatf("byte exp %02h got %02h, last exp %0b got %0b",
                                         want.data, m_axis_tdata, want.last, m_axis_tlast));
                end
            end
        end
    end

    initial begin
        held_cnt = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_ascii_roll();
        test_multibyte();
        test_stray();
        test_text_end();
        test_random(150);
        test_backpressure();
        no_gaps = 1'b1;
        test_random(70);
        no_gaps = 1'b0;
        test_random(110);
        // flush anything still held
        send_byte(8'h78, rand_shift(), 1'b1);
        s_axis_tvalid <= 1'b0;

        while (exp_bytes.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (n_errors == 0 && exp_bytes.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
